// ===== rtl/camera_box_aabb_axis_collision_macros.svh =====
// Assertion macros shared by the checker files of the camera box / AABB block.
// No dependencies; each macro expects clk and arst_n in scope.
`ifndef CAMERA_BOX_AABB_AXIS_COLLISION_MACROS_SVH
`define CAMERA_BOX_AABB_AXIS_COLLISION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CBAABB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbaabb assertion failed");

// Next-cycle implication, checked outside reset.
`define CBAABB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbaabb assertion failed");

`endif

// ===== rtl/cbaabb_pkg.sv =====
// Types, constants and helpers for the camera box / AABB collision block.
// No dependencies.
`default_nettype none
package cbaabb_pkg;

	localparam int COORD_BITS = 32;
	localparam int MAG_BITS   = COORD_BITS - 1;
	// Wide enough for a span edge minus a camera edge plus a move.
	localparam int GW         = COORD_BITS + 3;
	localparam int DATA_W     = (MAG_BITS > 32) ? 64 : 32;
	localparam int ADDR_W     = (DATA_W == 64) ? 6 : 5;
	localparam int IDX_LSB    = (DATA_W == 64) ? 3 : 2;
	localparam int IDX_W      = ADDR_W - IDX_LSB;

	localparam logic [IDX_W-1:0] REG_BOX_LEFT   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_BOX_RIGHT  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_BOX_BOTTOM = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_BOX_TOP    = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_BOX_BACK   = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_BOX_FRONT  = IDX_W'(5);

	typedef logic signed [GW-1:0] wide_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] aabb_pos_x;
		logic signed [COORD_BITS-1:0] aabb_pos_y;
		logic signed [COORD_BITS-1:0] aabb_pos_z;
		logic [MAG_BITS-1:0]          aabb_size_x;
		logic [MAG_BITS-1:0]          aabb_size_y;
		logic [MAG_BITS-1:0]          aabb_size_z;
		logic signed [COORD_BITS-1:0] cam_mid_x;
		logic signed [COORD_BITS-1:0] cam_mid_y;
		logic signed [COORD_BITS-1:0] cam_mid_z;
		logic signed [COORD_BITS-1:0] move_x;
		logic signed [COORD_BITS-1:0] move_y;
		logic signed [COORD_BITS-1:0] move_z;
	} query_t;

	typedef struct packed {
		logic overlap;
		logic hit_x;
		logic hit_y;
		logic hit_z;
	} result_t;

	// Per-axis verdict: pass is the overlap test, hit is not yet gated by overlap.
	typedef struct packed {
		logic pass;
		logic hit;
	} axis_res_t;

	function automatic wide_t sext_coord(input logic signed [COORD_BITS-1:0] v);
		return wide_t'({{(GW-COORD_BITS){v[COORD_BITS-1]}}, v});
	endfunction

	function automatic wide_t zext_mag(input logic [MAG_BITS-1:0] v);
		return wide_t'({{(GW-MAG_BITS){1'b0}}, v});
	endfunction

	// size >> 1, low bit dropped
	function automatic wide_t half_mag(input logic [MAG_BITS-1:0] v);
		return wide_t'({{(GW-MAG_BITS+1){1'b0}}, v[MAG_BITS-1:1]});
	endfunction

endpackage
`default_nettype wire

// ===== rtl/camera_box_aabb_axis_collision.sv =====
// Top level: camera box vs AABB overlap and per-axis collision test.
// Depends on cbaabb_pkg and cbaabb_axis.
//
//   channel   dir  handshake                  word
//   query     in   query_valid/query_ready    cbaabb_pkg::query_t
//   result    out  result_valid/result_ready  cbaabb_pkg::result_t
//   apb       in   psel/penable/pwrite        box extents, regs 0..5 at 4*i
//
// One word per cycle while the result is not stalled. A word passes the query
// register, then all three axis units in one combinational pass into the result
// register. A stalled result holds the result register; the query register keeps
// accepting as long as its word can move into the result register.
// arst_n clears the valid bits and the six extent registers (to 0).
`default_nettype none
module camera_box_aabb_axis_collision (
	input  var logic                              clk,
	input  var logic                              arst_n,
	// query channel
	input  var logic                              query_valid,
	output logic                                  query_ready,
	input  var cbaabb_pkg::query_t                query,
	// result channel
	output logic                                  result_valid,
	input  var logic                              result_ready,
	output cbaabb_pkg::result_t                   result,
	// configuration
	input  var logic                              psel,
	input  var logic                              penable,
	input  var logic                              pwrite,
	input  var logic [cbaabb_pkg::ADDR_W-1:0]     paddr,
	input  var logic [cbaabb_pkg::DATA_W-1:0]     pwdata,
	output logic [cbaabb_pkg::DATA_W-1:0]         prdata,
	output logic                                  pready
);
	import cbaabb_pkg::*;

	// ---------------- extent registers ----------------
	logic [MAG_BITS-1:0] box_left_q, box_right_q, box_bottom_q;
	logic [MAG_BITS-1:0] box_top_q, box_back_q, box_front_q;
	logic [IDX_W-1:0]    reg_idx;
	logic                cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:IDX_LSB];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q   <= '0;
			box_right_q  <= '0;
			box_bottom_q <= '0;
			box_top_q    <= '0;
			box_back_q   <= '0;
			box_front_q  <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_BOX_LEFT:   box_left_q   <= pwdata[MAG_BITS-1:0];
				REG_BOX_RIGHT:  box_right_q  <= pwdata[MAG_BITS-1:0];
				REG_BOX_BOTTOM: box_bottom_q <= pwdata[MAG_BITS-1:0];
				REG_BOX_TOP:    box_top_q    <= pwdata[MAG_BITS-1:0];
				REG_BOX_BACK:   box_back_q   <= pwdata[MAG_BITS-1:0];
				REG_BOX_FRONT:  box_front_q  <= pwdata[MAG_BITS-1:0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BOX_LEFT:   prdata = DATA_W'(box_left_q);
			REG_BOX_RIGHT:  prdata = DATA_W'(box_right_q);
			REG_BOX_BOTTOM: prdata = DATA_W'(box_bottom_q);
			REG_BOX_TOP:    prdata = DATA_W'(box_top_q);
			REG_BOX_BACK:   prdata = DATA_W'(box_back_q);
			REG_BOX_FRONT:  prdata = DATA_W'(box_front_q);
			default:        prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	query_t  query_s1;
	logic    valid_s1;
	result_t result_q;
	logic    result_valid_q;
	logic    adv_s1;       // stage 1 word may move into the result register
	result_t res_c;

	assign adv_s1       = !result_valid_q || result_ready;
	assign query_ready  = !valid_s1 || adv_s1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (query_ready)
				valid_s1 <= query_valid;
			if (adv_s1)
				result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (query_valid && query_ready)
			query_s1 <= query;
		if (adv_s1 && valid_s1)
			result_q <= res_c;
	end

	// ---------------- spans ----------------
	// X and Z are centred on the position with half size; Y rests on its position.
	wide_t x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
	wide_t l_w, r_w, b_w, t_w, bk_w, fr_w;

	always_comb begin
		x_lo = sext_coord(query_s1.aabb_pos_x) - half_mag(query_s1.aabb_size_x);
		x_hi = sext_coord(query_s1.aabb_pos_x) + half_mag(query_s1.aabb_size_x);
		y_lo = sext_coord(query_s1.aabb_pos_y);
		y_hi = sext_coord(query_s1.aabb_pos_y) + zext_mag(query_s1.aabb_size_y);
		z_lo = sext_coord(query_s1.aabb_pos_z) - half_mag(query_s1.aabb_size_z);
		z_hi = sext_coord(query_s1.aabb_pos_z) + half_mag(query_s1.aabb_size_z);
		l_w  = zext_mag(box_left_q);
		r_w  = zext_mag(box_right_q);
		b_w  = zext_mag(box_bottom_q);
		t_w  = zext_mag(box_top_q);
		bk_w = zext_mag(box_back_q);
		fr_w = zext_mag(box_front_q);
	end

	axis_res_t ax_x, ax_y, ax_z;

	cbaabb_axis u_axis_x (
		.span_lo (x_lo),
		.span_hi (x_hi),
		.mid     (sext_coord(query_s1.cam_mid_x)),
		.ov_dn   (l_w),
		.ov_up   (r_w),
		.gap_up  (r_w),
		.gap_dn  (l_w),
		.move    (sext_coord(query_s1.move_x)),
		.res     (ax_x)
	);

	cbaabb_axis u_axis_y (
		.span_lo (y_lo),
		.span_hi (y_hi),
		.mid     (sext_coord(query_s1.cam_mid_y)),
		.ov_dn   (b_w),
		.ov_up   (t_w),
		.gap_up  (t_w),
		.gap_dn  (b_w),
		.move    (sext_coord(query_s1.move_y)),
		.res     (ax_y)
	);

	// Z keeps the crossed roles: back/front swap between overlap and gap.
	cbaabb_axis u_axis_z (
		.span_lo (z_lo),
		.span_hi (z_hi),
		.mid     (sext_coord(query_s1.cam_mid_z)),
		.ov_dn   (bk_w),
		.ov_up   (fr_w),
		.gap_up  (bk_w),
		.gap_dn  (fr_w),
		.move    (sext_coord(query_s1.move_z)),
		.res     (ax_z)
	);

	always_comb begin
		res_c.overlap = ax_x.pass && ax_y.pass && ax_z.pass;
		res_c.hit_x   = res_c.overlap && ax_x.hit;
		res_c.hit_y   = res_c.overlap && ax_y.hit;
		res_c.hit_z   = res_c.overlap && ax_z.hit;
	end

endmodule
`default_nettype wire

// ===== rtl/cbaabb_axis.sv =====
// One axis of the overlap and collision test: camera edges against an AABB span.
// Depends on cbaabb_pkg.
`default_nettype none
module cbaabb_axis (
	input  var cbaabb_pkg::wide_t     span_lo,
	input  var cbaabb_pkg::wide_t     span_hi,
	input  var cbaabb_pkg::wide_t     mid,
	input  var cbaabb_pkg::wide_t     ov_dn,
	input  var cbaabb_pkg::wide_t     ov_up,
	input  var cbaabb_pkg::wide_t     gap_up,
	input  var cbaabb_pkg::wide_t     gap_dn,
	input  var cbaabb_pkg::wide_t     move,
	output cbaabb_pkg::axis_res_t     res
);
	import cbaabb_pkg::*;

	wide_t lo_e, hi_e, gp, gn, gp_sum, gp_dif, gn_sum, gn_dif;
	logic  in_span, covers, mv_pos, mv_neg;

	always_comb begin
		lo_e    = mid - ov_dn;
		hi_e    = mid + ov_up;
		in_span = (hi_e > span_lo && hi_e < span_hi) || (lo_e < span_hi && lo_e > span_lo);
		covers  = (hi_e >= span_hi) && (lo_e <= span_lo);

		gp     = span_lo - (mid + gap_up);
		gn     = span_hi - (mid - gap_dn);
		mv_neg = move[GW-1];
		mv_pos = !move[GW-1] && (move != '0);

		// |g| <= |move| written as -|move| <= g <= |move|, no negation needed
		gp_sum = gp + move;
		gp_dif = gp - move;
		gn_sum = gn + move;
		gn_dif = gn - move;

		res.pass = in_span || covers;
		res.hit  = (mv_pos && !gp_sum[GW-1] && (gp_dif[GW-1] || gp_dif == '0))
		        || (mv_neg && !gn_dif[GW-1] && (gn_sum[GW-1] || gn_sum == '0));
	end

endmodule
`default_nettype wire

// ===== rtl/cbaabb_checker.sv =====
// Port-level checker for the camera box / AABB block, bound to the top level.
// Depends on cbaabb_pkg and camera_box_aabb_axis_collision_macros.svh.
`default_nettype none
`include "camera_box_aabb_axis_collision_macros.svh"
module cbaabb_checker (
	input var logic                          clk,
	input var logic                          arst_n,
	input var logic                          query_valid,
	input var logic                          query_ready,
	input var logic                          result_valid,
	input var logic                          result_ready,
	input var cbaabb_pkg::result_t           result
);
	import cbaabb_pkg::*;

	// a hit is only reported on an overlapping box
	`CBAABB_ASSERT_NOW(a_hit_needs_overlap, result_valid && !result.overlap, !result.hit_x && !result.hit_y && !result.hit_z)
	// a stalled result word holds
	`CBAABB_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))
	// empty output side never blocks the query side
	`CBAABB_ASSERT_NOW(a_ready_when_empty, !result_valid, query_ready)
	// an accepted query reaches the result register when the sink is draining
	`CBAABB_ASSERT_NEXT(a_latency, (query_valid && query_ready) ##1 result_ready, result_valid)

endmodule

bind camera_box_aabb_axis_collision cbaabb_checker u_cbaabb_checker (.*);
`default_nettype wire

// ===== dv/tb_camera_box_aabb_axis_collision.sv =====
// Self-checking testbench for camera_box_aabb_axis_collision: predicts the overlap and
// per-axis hit flags of every query word and compares them with the result channel.
// Depends on cbaabb_pkg and the RTL of the block.
`default_nettype none
module tb_camera_box_aabb_axis_collision;
	import cbaabb_pkg::*;

	// Quiet cycles (no word moved on any port) before the run is declared hung.
	localparam int QUIET_LIMIT   = 2000;
	// Pipeline is two registers deep; a few extra cycles cover any slack.
	localparam int SETTLE_CYCLES = 8;
	localparam int PRINT_LIMIT   = 50;
	localparam int PHASES        = 9;
	localparam int PHASE_WORDS   = 50;

	// Address slot just past the last extent register: writes there must be dropped.
	localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(REG_BOX_FRONT + 1);

	localparam longint COORD_MIN = -64'sd2147483648;
	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint SIZE_MAX  = 64'sd2147483647;

	// Clock, reset and every block input start at a known value.
	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                query_valid  = 1'b0;
	query_t              query        = '0;
	logic                result_ready = 1'b0;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [ADDR_W-1:0]   paddr        = '0;
	logic [DATA_W-1:0]   pwdata       = '0;

	logic                query_ready;
	logic                result_valid;
	result_t             result;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// Testbench copy of the six camera box extents, as the block should hold them.
	logic [MAG_BITS-1:0] box_extent [0:5] = '{default: '0};

	query_t  pending_queries  [$];
	result_t expected_results [$];

	int send_idle_max = 0;
	int recv_idle_max = 0;
	int send_gap      = 0;
	int recv_wait     = 0;
	int mismatches    = 0;
	int result_count  = 0;
	int quiet_cycles  = 0;

	camera_box_aabb_axis_collision dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_ready  (query_ready),
		.query        (query),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction. All edges are formed exactly in 64 bits, well above the
	// 35 bits the block uses, so no sum or difference can wrap.
	// ------------------------------------------------------------------
	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// An axis passes when either camera edge sits strictly inside the AABB
	// span, or the camera span covers the AABB span with equality allowed.
	function automatic bit axis_overlaps(input longint lo, input longint hi,
			input longint cam_lo, input longint cam_hi);
		bit inside_span;
		bit covers_span;
		inside_span = (cam_hi > lo && cam_hi < hi) || (cam_lo < hi && cam_lo > lo);
		covers_span = (cam_hi >= hi) && (cam_lo <= lo);
		return inside_span || covers_span;
	endfunction

	// Positive move is tested against the gap to the lower face, negative
	// move against the gap to the upper face; zero move never hits.
	function automatic bit axis_collides(input longint gap_up, input longint gap_down,
			input longint move);
		longint move_mag;
		move_mag = magnitude(move);
		return (move > 0 && magnitude(gap_up) <= move_mag) ||
			(move < 0 && magnitude(gap_down) <= move_mag);
	endfunction

	function automatic result_t predict_collision(input query_t q);
		longint  px, py, pz, sy, half_x, half_z, mx, my, mz;
		longint  ext_l, ext_r, ext_b, ext_t, ext_bk, ext_fr;
		longint  x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
		result_t r;
		px     = longint'(q.aabb_pos_x);
		py     = longint'(q.aabb_pos_y);
		pz     = longint'(q.aabb_pos_z);
		mx     = longint'(q.cam_mid_x);
		my     = longint'(q.cam_mid_y);
		mz     = longint'(q.cam_mid_z);
		// odd sizes lose the low bit on X and Z; Y uses the full height
		half_x = longint'(q.aabb_size_x) >> 1;
		half_z = longint'(q.aabb_size_z) >> 1;
		sy     = longint'(q.aabb_size_y);
		ext_l  = longint'(box_extent[REG_BOX_LEFT]);
		ext_r  = longint'(box_extent[REG_BOX_RIGHT]);
		ext_b  = longint'(box_extent[REG_BOX_BOTTOM]);
		ext_t  = longint'(box_extent[REG_BOX_TOP]);
		ext_bk = longint'(box_extent[REG_BOX_BACK]);
		ext_fr = longint'(box_extent[REG_BOX_FRONT]);
		x_lo   = px - half_x;
		x_hi   = px + half_x;
		y_lo   = py;
		y_hi   = py + sy;
		z_lo   = pz - half_z;
		z_hi   = pz + half_z;
		r         = '0;
		r.overlap = axis_overlaps(x_lo, x_hi, mx - ext_l, mx + ext_r) &&
			axis_overlaps(y_lo, y_hi, my - ext_b, my + ext_t) &&
			axis_overlaps(z_lo, z_hi, mz - ext_bk, mz + ext_fr);
		if (r.overlap) begin
			r.hit_x = axis_collides(x_lo - (mx + ext_r), x_hi - (mx - ext_l),
				longint'(q.move_x));
			r.hit_y = axis_collides(y_lo - (my + ext_t), y_hi - (my - ext_b),
				longint'(q.move_y));
			// Z swaps the roles of back and front between the two tests
			r.hit_z = axis_collides(z_lo - (mz + ext_bk), z_hi - (mz - ext_fr),
				longint'(q.move_z));
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic query_t make_query(input longint px, py, pz, sx, sy, sz,
			input longint mx, my, mz, dx, dy, dz);
		query_t q;
		q.aabb_pos_x  = px[COORD_BITS-1:0];
		q.aabb_pos_y  = py[COORD_BITS-1:0];
		q.aabb_pos_z  = pz[COORD_BITS-1:0];
		q.aabb_size_x = sx[MAG_BITS-1:0];
		q.aabb_size_y = sy[MAG_BITS-1:0];
		q.aabb_size_z = sz[MAG_BITS-1:0];
		q.cam_mid_x   = mx[COORD_BITS-1:0];
		q.cam_mid_y   = my[COORD_BITS-1:0];
		q.cam_mid_z   = mz[COORD_BITS-1:0];
		q.move_x      = dx[COORD_BITS-1:0];
		q.move_y      = dy[COORD_BITS-1:0];
		q.move_z      = dz[COORD_BITS-1:0];
		return q;
	endfunction

	// scale 0: a tight window so edges, gaps and moves tie often;
	// scale 1: around Q16.16 unit sizes; scale 2: any 32-bit value.
	function automatic logic [COORD_BITS-1:0] pick_coord(input int scale);
		case (scale)
			0: return COORD_BITS'(int'($urandom_range(0, 32)) - 16);
			1: return COORD_BITS'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [MAG_BITS-1:0] pick_size(input int scale);
		case (scale)
			0: return MAG_BITS'($urandom_range(0, 24));
			1: return MAG_BITS'($urandom_range(0, 1 << 21));
			default: return MAG_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [COORD_BITS-1:0] pick_move(input int scale);
		case ($urandom_range(0, 19))
			0: return '0;
			1: return COORD_MIN[COORD_BITS-1:0];
			2: return COORD_MAX[COORD_BITS-1:0];
			default: return pick_coord(scale);
		endcase
	endfunction

	// Camera middles are placed near the AABB for the first two scales so
	// that most words overlap and exercise the hit logic.
	function automatic query_t random_query();
		query_t q;
		int     scale;
		int     sel;
		sel   = $urandom_range(0, 19);
		scale = (sel < 12) ? 0 : (sel < 17) ? 1 : 2;
		q.aabb_pos_x  = pick_coord(scale);
		q.aabb_pos_y  = pick_coord(scale);
		q.aabb_pos_z  = pick_coord(scale);
		q.aabb_size_x = pick_size(scale);
		q.aabb_size_y = pick_size(scale);
		q.aabb_size_z = pick_size(scale);
		q.cam_mid_x   = (scale == 2) ? $urandom : q.aabb_pos_x + pick_coord(scale);
		q.cam_mid_y   = (scale == 2) ? $urandom : q.aabb_pos_y + pick_coord(scale);
		q.cam_mid_z   = (scale == 2) ? $urandom : q.aabb_pos_z + pick_coord(scale);
		q.move_x      = pick_move(scale);
		q.move_y      = pick_move(scale);
		q.move_z      = pick_move(scale);
		return q;
	endfunction

	// Setup cycle, then access cycle; the register takes pwdata at the edge
	// that ends the access cycle. Only the low 31 bits are kept.
	task automatic write_extent(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, {IDX_LSB{1'b0}}};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx <= REG_BOX_FRONT) begin
			box_extent[idx] = value[MAG_BITS-1:0];
		end
	endtask

	task automatic set_box(input logic [DATA_W-1:0] l, r, b, t, bk, fr);
		write_extent(REG_BOX_LEFT,   l);
		write_extent(REG_BOX_RIGHT,  r);
		write_extent(REG_BOX_BOTTOM, b);
		write_extent(REG_BOX_TOP,    t);
		write_extent(REG_BOX_BACK,   bk);
		write_extent(REG_BOX_FRONT,  fr);
	endtask

	// Holds the sender until every expected result has come back, then lets
	// the pipeline run dry so register writes land on an idle block.
	task automatic wait_settled();
		do begin
			@(negedge clk);
		end while (pending_queries.size() != 0 || query_valid ||
			expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT) begin
			$display("ERROR result word %0d: %s", result_count, msg);
		end
	endtask

	// ------------------------------------------------------------------
	// Query driver: one word at a time from pending_queries, with a random
	// idle gap, bounded by send_idle_max, before the next word goes out.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (query_valid && query_ready) begin
				expected_results.push_back(predict_collision(query));
			end
			// a word still waiting for ready keeps valid and payload as they are
			if (!(query_valid && !query_ready)) begin
				if (send_gap != 0) begin
					send_gap--;
					query_valid <= 1'b0;
				end else if (pending_queries.size() != 0) begin
					query       <= pending_queries.pop_front();
					query_valid <= 1'b1;
					send_gap = $urandom_range(0, send_idle_max);
				end else begin
					query_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: ready drops for a random spell, up to recv_idle_max, after
	// each word; every accepted word is checked against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (result_valid && result_ready) begin
				result_count++;
				if (expected_results.size() == 0) begin
					report_mismatch("result word with no query outstanding");
				end else begin
					want = expected_results.pop_front();
					if (result.overlap !== want.overlap)
						report_mismatch($sformatf("overlap got %b want %b",
							result.overlap, want.overlap));
					if (result.hit_x !== want.hit_x)
						report_mismatch($sformatf("hit_x got %b want %b",
							result.hit_x, want.hit_x));
					if (result.hit_y !== want.hit_y)
						report_mismatch($sformatf("hit_y got %b want %b",
							result.hit_y, want.hit_y));
					if (result.hit_z !== want.hit_z)
						report_mismatch($sformatf("hit_z got %b want %b",
							result.hit_z, want.hit_z));
				end
				recv_wait = $urandom_range(0, recv_idle_max);
			end else if (recv_wait != 0) begin
				recv_wait--;
			end
			result_ready <= (recv_wait == 0);
		end
	end

	// Watchdog: any word moved on any port restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((query_valid && query_ready) || (result_valid && result_ready) ||
					(psel && penable && pwrite && pready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no traffic for %0d cycles", QUIET_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		query_t directed [$];
		int     p;
		int     n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words: the camera box is a point while the extents are
		// still at reset, then the same words run against the widest box.
		directed.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// move exactly equal to the face gap, both signs
		directed.push_back(make_query(0, 0, 0, 10, 10, 10, 0, 3, 0, 5, -3, -5));
		directed.push_back(make_query(0, 0, 0, 10, 10, 10, 0, 3, 0, -4, 7, 4));
		// odd sizes: half sizes drop the low bit on X and Z only
		directed.push_back(make_query(0, 0, 0, 11, 11, 11, 0, 10, 0, 5, -10, -5));
		// camera on the AABB faces: no strict inside, no cover
		directed.push_back(make_query(0, 0, 0, 10, 10, 10, 5, 10, 5, 1, 1, 1));
		// far apart with large moves: no overlap, so no hit either
		directed.push_back(make_query(100, 0, 0, 10, 10, 10, 0, 0, 0, 200, 200, 200));
		directed.push_back(make_query(COORD_MIN, COORD_MIN, COORD_MIN,
			SIZE_MAX, SIZE_MAX, SIZE_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN));
		directed.push_back(make_query(COORD_MAX, COORD_MAX, COORD_MAX,
			SIZE_MAX, SIZE_MAX, SIZE_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX));
		directed.push_back(make_query(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
		// most negative move against huge spans: its magnitude must not wrap
		directed.push_back(make_query(0, 0, 0, SIZE_MAX, SIZE_MAX, SIZE_MAX,
			0, 0, 0, COORD_MIN, COORD_MIN, COORD_MIN));
		directed.push_back(make_query(0, COORD_MIN, 0, SIZE_MAX, SIZE_MAX, SIZE_MAX,
			0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX));

		send_idle_max = 0;
		recv_idle_max = 0;
		foreach (directed[i]) pending_queries.push_back(directed[i]);
		wait_settled();

		// widest box; bit 31 of the write data must be dropped, and a write
		// past the last register must leave every extent alone
		set_box('1, '1, '1, '1, '1, '1);
		write_extent(REG_SPARE, 32'h0000_0000);
		send_idle_max = 4;
		recv_idle_max = 4;
		@(negedge clk);
		foreach (directed[i]) pending_queries.push_back(directed[i]);
		wait_settled();

		// Random phases, each under a fresh box setting. Every third phase
		// runs back to back with no gaps on either side.
		for (p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: set_box($urandom_range(0, 16), $urandom_range(0, 16),
					$urandom_range(0, 16), $urandom_range(0, 16),
					$urandom_range(0, 16), $urandom_range(0, 16));
				1: set_box($urandom_range(0, 1 << 21), $urandom_range(0, 1 << 21),
					$urandom_range(0, 1 << 21), $urandom_range(0, 1 << 21),
					$urandom_range(0, 1 << 21), $urandom_range(0, 1 << 21));
				2: begin
					set_box(0, $urandom_range(0, 8), 0, $urandom_range(0, 8),
						$urandom_range(0, 8), 0);
					write_extent(REG_SPARE, $urandom);
				end
				default: set_box($urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
			endcase
			send_idle_max = (p % 3 == 0) ? 0 : 4;
			recv_idle_max = (p % 3 == 0) ? 0 : 4;
			@(negedge clk);
			for (n = 0; n < PHASE_WORDS; n++) pending_queries.push_back(random_query());
			wait_settled();
		end

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
`default_nettype wire
